// File: design/three_digit_seven_segment_scanner_core_defines.svh
// Assertion macros shared by the checker of the seven-segment scanner core.
// Depends on nothing; included by the files that hold concurrent assertions.
`ifndef THREE_DIGIT_SEVEN_SEGMENT_SCANNER_CORE_DEFINES_SVH
`define THREE_DIGIT_SEVEN_SEGMENT_SCANNER_CORE_DEFINES_SVH

// General form: explicit clock and active-low reset.
`define TDSS_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Short form for modules that use clk_i and rst_ni.
`define TDSS_ASSERT(name, prop, msg) \
  `TDSS_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

// File: design/tdss_pkg.sv
// Shared types, constants and helper functions of the seven-segment scanner.
// Depends on nothing; every other design file but the macro header imports it.
package tdss_pkg;

  localparam int unsigned DigitCountDef = 3;
  localparam int unsigned ReqTypeW      = 2;
  localparam int unsigned ValueW        = 10;
  localparam int unsigned SegW          = 28;
  localparam int unsigned EnW           = 3;
  localparam int unsigned DigitW        = 4;

  // Pin bits that the segment drive may change.
  localparam logic [SegW-1:0] SegMask = 28'h8CB2000;

  typedef enum logic [ReqTypeW-1:0] {
    ReqWrite = 2'd0,
    ReqTick  = 2'd1,
    ReqPoint = 2'd2
  } req_e;

  typedef struct packed {
    logic [SegW-1:0] seg;
    logic [EnW-1:0]  en;
    logic            point;
  } pin_state_t;

  // Segment code per decimal digit; a set bit is a lit segment.
  function automatic logic [SegW-1:0] seg_code(input logic [DigitW-1:0] d);
    logic [SegW-1:0] code;
    case (d)
      4'd0:    code = 28'h8CB0000;
      4'd1:    code = 28'h0480000;
      4'd2:    code = 28'h8432000;
      4'd3:    code = 28'h04B2000;
      4'd4:    code = 28'h0C82000;
      4'd5:    code = 28'h08B2000;
      4'd6:    code = 28'h88B2000;
      4'd7:    code = 28'h04A0000;
      4'd8:    code = 28'h8CB2000;
      4'd9:    code = 28'h0CB2000;
      default: code = '0;
    endcase
    return code;
  endfunction

  // Division by ten through the reciprocal 205/2048, exact below 1029.
  function automatic logic [ValueW-1:0] div10(input logic [ValueW-1:0] v);
    logic [20:0] prod;
    prod = 21'(v) * 21'd205;
    return prod[20:11];
  endfunction

  function automatic int unsigned pow10(input int unsigned n);
    int unsigned p;
    p = 1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

endpackage

// File: design/tdss_req_if.sv
// Request channel of the scanner: valid/ready handshake and request payload.
// Depends on tdss_pkg for the field widths.
interface tdss_req_if;
  import tdss_pkg::*;

  logic                valid;
  logic                ready;
  logic [ReqTypeW-1:0] req_type;
  logic [ValueW-1:0]   display_value;
  logic                point_level;

  modport source (output valid, output req_type, output display_value,
                  output point_level, input ready);
  modport sink   (input valid, input req_type, input display_value,
                  input point_level, output ready);
endinterface

// File: design/tdss_res_if.sv
// Result channel of the scanner: valid/ready handshake and pin levels.
// Depends on tdss_pkg for the field widths.
interface tdss_res_if;
  import tdss_pkg::*;

  logic            valid;
  logic            ready;
  logic [SegW-1:0] segment_pins;
  logic [EnW-1:0]  digit_enables;
  logic            point_pin;

  modport source (output valid, output segment_pins, output digit_enables,
                  output point_pin, input ready);
  modport sink   (input valid, input segment_pins, input digit_enables,
                  input point_pin, output ready);
endinterface

// File: design/tdss_digit_split.sv
// Saturates a value to the displayable range and splits it into BCD digits.
// Depends on tdss_pkg (div10, pow10, widths).
module tdss_digit_split #(
  parameter int unsigned DIGIT_COUNT = tdss_pkg::DigitCountDef
) (
  input  logic [tdss_pkg::ValueW-1:0]                   value_i,
  output logic [tdss_pkg::DigitW*DIGIT_COUNT-1:0]       digits_o
);
  import tdss_pkg::*;

  localparam logic [31:0] Limit = 32'(pow10(DIGIT_COUNT) - 1);

  logic [ValueW-1:0] sat;
  logic [ValueW-1:0] rest;
  logic [ValueW-1:0] quot;
  logic [ValueW-1:0] rem;

  assign sat = (32'(value_i) > Limit) ? Limit[ValueW-1:0] : value_i;

  // Least significant digit goes to the highest position.
  always_comb begin
    rest     = sat;
    quot     = '0;
    rem      = '0;
    digits_o = '0;
    for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
      quot = div10(rest);
      rem  = rest - ValueW'(quot * ValueW'(10));
      digits_o[DigitW*i +: DigitW] = rem[DigitW-1:0];
      rest = quot;
    end
  end

endmodule

// File: design/tdss_scan.sv
// Display state: stored digits, scan position and the pin levels.
// Depends on tdss_pkg (seg_code, req_e, pin_state_t).
module tdss_scan #(
  parameter int unsigned DIGIT_COUNT = tdss_pkg::DigitCountDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    step_i,
  input  tdss_pkg::req_e                          req_i,
  input  logic [tdss_pkg::DigitW*DIGIT_COUNT-1:0] digits_i,
  input  logic                                    point_i,
  output tdss_pkg::pin_state_t                    pins_o
);
  import tdss_pkg::*;

  localparam int unsigned StoreW = DigitW * DIGIT_COUNT;
  localparam int unsigned PosW   = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic [StoreW-1:0] digits_q, digits_d;
  logic [PosW-1:0]   pos_q, pos_d;
  pin_state_t        pins_q, pins_d;
  logic [SegW-1:0]   code;

  assign code = seg_code(digits_q[DigitW*pos_q +: DigitW]);

  always_comb begin
    digits_d = digits_q;
    pos_d    = pos_q;
    pins_d   = pins_q;
    case (req_i)
      ReqWrite: digits_d = digits_i;
      ReqTick: begin
        pins_d.seg = (pins_q.seg | (~code & SegMask)) & ~code;
        // Positions beyond the enable field leave all enables off.
        for (int k = 0; k < EnW; k++) begin
          pins_d.en[k] = (32'(pos_q) == k);
        end
        pos_d = (pos_q == PosW'(DIGIT_COUNT - 1)) ? '0 : pos_q + PosW'(1);
      end
      ReqPoint: pins_d.point = point_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= '0;
      pos_q    <= '0;
      pins_q   <= '0;
    end else if (step_i) begin
      digits_q <= digits_d;
      pos_q    <= pos_d;
      pins_q   <= pins_d;
    end
  end

  assign pins_o = pins_d;

endmodule

// File: design/three_digit_seven_segment_scanner_core.sv
// Multiplexed seven-segment display driver. Each request (write a value, scan
// tick, or set the decimal point) yields one result with the pin levels held
// after it. A request is taken into an input register; once the output
// register is free it is applied to the display state and its result lands
// in the output register. The core takes one request every cycle; ready
// drops only when a result waits in the output register and the sink stalls.
// The digit split is a reciprocal multiply per digit between the two
// registers and is what sets the clock period.
module three_digit_seven_segment_scanner_core #(
  parameter int unsigned DIGIT_COUNT = tdss_pkg::DigitCountDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdss_req_if.sink   req_i,
  tdss_res_if.source res_o
);
  import tdss_pkg::*;

  localparam int unsigned StoreW = DigitW * DIGIT_COUNT;

  logic              in_valid_q;
  req_e              req_q;
  logic [ValueW-1:0] value_q;
  logic              point_q;
  logic              advance;
  logic [StoreW-1:0] digits;
  pin_state_t        pins_next;
  logic              res_valid_q;
  pin_state_t        res_q;

  // The staged request moves on whenever the output register is free.
  assign advance     = in_valid_q && (!res_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q   <= req_e'(req_i.req_type);
      value_q <= req_i.display_value;
      point_q <= req_i.point_level;
    end
  end

  tdss_digit_split #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_split (
    .value_i  (value_q),
    .digits_o (digits)
  );

  tdss_scan #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .req_i    (req_q),
    .digits_i (digits),
    .point_i  (point_q),
    .pins_o   (pins_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= pins_next;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.segment_pins  = res_q.seg;
  assign res_o.digit_enables = res_q.en;
  assign res_o.point_pin     = res_q.point;

endmodule

// File: design/tdss_checker.sv
// Port-level checks of the scanner core and the bind that attaches them.
// Depends on tdss_pkg and three_digit_seven_segment_scanner_core_defines.svh.
`include "three_digit_seven_segment_scanner_core_defines.svh"

module tdss_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [tdss_pkg::SegW-1:0]     segment_pins_i,
  input logic [tdss_pkg::EnW-1:0]      digit_enables_i,
  input logic                          point_pin_i
);
  import tdss_pkg::*;

  // A stalled result keeps its valid and its payload.
  `TDSS_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i && $stable(segment_pins_i) && $stable(digit_enables_i) && $stable(point_pin_i), "stalled result changed")

  // With no result pending the core never pushes back on a request.
  `TDSS_ASSERT(a_no_false_stall, req_valid_i && !res_valid_i |-> req_ready_i, "request stalled with empty output")

  // At most one digit is enabled at any time.
  `TDSS_ASSERT(a_enable_onehot, res_valid_i |-> $onehot0(digit_enables_i), "more than one digit enabled")

  // Pins outside the segment mask never leave their reset level.
  `TDSS_ASSERT(a_mask_only, res_valid_i |-> (segment_pins_i & ~SegMask) == '0, "pin outside segment mask driven")

endmodule

bind three_digit_seven_segment_scanner_core tdss_checker u_tdss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .segment_pins_i  (res_o.segment_pins),
  .digit_enables_i (res_o.digit_enables),
  .point_pin_i     (res_o.point_pin)
);
